// ===== hw/rtl/fcc_pkg.sv =====
package fcc_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KEY_W   = 48;
    localparam int HDL_W   = 16;
    localparam int CNT_W   = 32;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_PUSH   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [15:0] key_x;
        logic signed [15:0] key_y;
        logic signed [15:0] key_z;
        logic [HDL_W-1:0]   handle;
    } t_in;

    typedef struct packed {
        logic             hit;
        logic [HDL_W-1:0] found_handle;
        logic [CNT_W-1:0] hit_count;
        logic [CNT_W-1:0] miss_count;
    } t_out;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [HDL_W-1:0] handle;
    } t_slot;

    // finished item from the sequencer to the output stage
    typedef struct packed {
        logic             valid;
        logic             lookup;
        logic             hit;
        logic [HDL_W-1:0] found;
    } t_res;

endpackage

// ===== hw/rtl/fifo_region_chunk_cache.sv =====
// region-to-chunk cache with fifo replacement, ENTRIES slots (fcc_pkg)
// input channel i_in_valid / o_in_ready carries a command word: lookup,
// push, clear or no operation, with a 3d region key and a chunk handle.
// output channel o_out_valid / i_out_ready returns one word per command:
// hit flag, matching handle and the saturating hit and miss counters.
// a single equality unit walks the slots newest first, one slot per cycle,
// fed by the one read port of the slot store. a lookup stops at its first
// match, a push stops at a present handle, otherwise all ENTRIES slots are
// visited and a new push is written over the oldest slot.
// a word is accepted only while the sequencer is idle; a lookup or push then
// scans the slots, a clear or no operation goes straight to the done state,
// and from there the result is loaded into the output register. one word is
// in work at a time.
// the output register lets the next word be accepted while a result waits;
// a stalled receiver holds the result and, once the next word finishes,
// holds the sequencer too.
// synchronous active-low reset empties all slots and zeroes both counters.
module fifo_region_chunk_cache (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  fcc_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output fcc_pkg::t_out o_out_data
);
    import fcc_pkg::*;

    t_res             res;
    logic             res_ready;
    logic             r_out_valid;
    t_out             r_out_data;
    logic [CNT_W-1:0] r_hits;
    logic [CNT_W-1:0] r_misses;
    logic [CNT_W-1:0] n_hits;
    logic [CNT_W-1:0] n_misses;

    fcc_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    assign res_ready = !r_out_valid || i_out_ready;

    always_comb begin
        n_hits   = r_hits;
        n_misses = r_misses;
        if (res.lookup) begin
            if (res.hit) begin
                n_hits = (r_hits == '1) ? r_hits : r_hits + 1'b1;
            end else begin
                n_misses = (r_misses == '1) ? r_misses : r_misses + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_hits      <= '0;
            r_misses    <= '0;
        end else if (res.valid && res_ready) begin
            r_out_valid                <= 1'b1;
            r_hits                     <= n_hits;
            r_misses                   <= n_misses;
            r_out_data.hit             <= res.lookup && res.hit;
            r_out_data.found_handle    <= (res.lookup && res.hit) ? res.found : '0;
            r_out_data.hit_count       <= n_hits;
            r_out_data.miss_count      <= n_misses;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== hw/rtl/fcc_cmp.sv =====
module fcc_cmp (
    input  logic                    i_sel_key,
    input  logic [fcc_pkg::KEY_W-1:0] i_key,
    input  logic [fcc_pkg::HDL_W-1:0] i_handle,
    input  fcc_pkg::t_slot          i_slot,
    input  logic                    i_slot_valid,
    output logic                    o_match
);
    import fcc_pkg::*;

    logic [KEY_W-1:0] op_a;
    logic [KEY_W-1:0] op_b;

    // one equality unit: key compare for lookups, handle compare for pushes
    assign op_a = i_sel_key ? i_key : {{(KEY_W-HDL_W){1'b0}}, i_handle};
    assign op_b = i_sel_key ? i_slot.key : {{(KEY_W-HDL_W){1'b0}}, i_slot.handle};

    assign o_match = i_slot_valid && (op_a == op_b);

endmodule

// ===== hw/rtl/fcc_seq.sv =====
module fcc_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  fcc_pkg::t_in   i_in_data,
    output fcc_pkg::t_res  o_res,
    input  logic           i_res_ready
);
    import fcc_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state             r_state;
    t_cmd               r_cmd;
    logic [KEY_W-1:0]   r_key;
    logic [HDL_W-1:0]   r_handle;
    logic               r_hit;
    logic [HDL_W-1:0]   r_found;
    logic [IDX_W-1:0]   r_head;
    logic [IDX_W-1:0]   r_cmp_addr;
    logic [IDX_W-1:0]   r_cmp_n;
    logic [ENTRIES-1:0] r_valid;

    t_slot              r_mem [ENTRIES];
    t_slot              r_rd_slot;

    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   next_addr;
    logic [IDX_W-1:0]   head_dec;
    logic               last;
    logic               match;
    logic               wr_en;
    t_slot              wr_slot;

    assign last      = (r_cmp_n == LAST_IDX);
    assign next_addr = (r_cmp_addr == LAST_IDX) ? '0 : r_cmp_addr + 1'b1;
    assign head_dec  = (r_head == '0) ? LAST_IDX : r_head - 1'b1;
    assign rd_addr   = (r_state == S_IDLE) ? r_head : next_addr;
    assign wr_en     = (r_state == S_SCAN) && (r_cmd == CMD_PUSH) && !match && last;
    assign wr_slot   = '{key: r_key, handle: r_handle};

    fcc_cmp u_cmp (
        .i_sel_key    (r_cmd == CMD_LOOKUP),
        .i_key        (r_key),
        .i_handle     (r_handle),
        .i_slot       (r_rd_slot),
        .i_slot_valid (r_valid[r_cmp_addr]),
        .o_match      (match)
    );

    // slot store, circular: slot i lives at address head + i
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[head_dec] <= wr_slot;
        end
        r_rd_slot <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= CMD_NOP;
            r_head  <= '0;
            r_valid <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd      <= i_in_data.cmd;
                        r_key      <= {i_in_data.key_x, i_in_data.key_y, i_in_data.key_z};
                        r_handle   <= i_in_data.handle;
                        r_hit      <= 1'b0;
                        r_found    <= '0;
                        r_cmp_addr <= r_head;
                        r_cmp_n    <= '0;
                        if (i_in_data.cmd == CMD_LOOKUP || i_in_data.cmd == CMD_PUSH) begin
                            r_state <= S_SCAN;
                        end else begin
                            if (i_in_data.cmd == CMD_CLEAR) begin
                                r_valid <= '0;
                            end
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    r_cmp_addr <= next_addr;
                    r_cmp_n    <= r_cmp_n + 1'b1;
                    if (match) begin
                        // newest match wins for lookup; present handle ends a push
                        if (r_cmd == CMD_LOOKUP) begin
                            r_hit   <= 1'b1;
                            r_found <= r_rd_slot.handle;
                        end
                        r_state <= S_DONE;
                    end else if (last) begin
                        if (r_cmd == CMD_PUSH) begin
                            r_head            <= head_dec;
                            r_valid[head_dec] <= 1'b1;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_res.valid  = (r_state == S_DONE);
    assign o_res.lookup = (r_cmd == CMD_LOOKUP);
    assign o_res.hit    = r_hit;
    assign o_res.found  = r_found;

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_in_data.cmd == CMD_CLEAR) |=> (r_valid == '0))
        else $error("clear left a valid slot");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cmp_n <= LAST_IDX))
        else $error("scan ran past the last slot");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= LAST_IDX)
        else $error("head pointer out of range");

    a_hit_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.hit) |-> (r_cmd == CMD_LOOKUP))
        else $error("hit reported for a non-lookup word");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_valid[r_head])
        else $error("pushed slot not marked valid");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import fcc_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    fifo_region_chunk_cache i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #3_200_000;
        $display("fifo_region_chunk_cache test failed");
        $finish;
    end

    // mirror of the slot store, newest entry in slot 0
    logic [KEY_W-1:0] cache_key    [ENTRIES];
    logic [HDL_W-1:0] cache_handle [ENTRIES];
    logic             cache_valid  [ENTRIES];
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;

    t_out expected_words[$];
    int unsigned mismatch_count = 0;
    bit stall_request = 1'b0;

    typedef struct {
        t_in  word;
        bit   typed;
        t_out result;
    } t_dir_row;

    t_dir_row dir_rows[$];
    logic [KEY_W-1:0] key_pool[12];
    int unsigned burst_left = 0;

    function automatic void cache_clear_all();
        for (int i = 0; i < ENTRIES; i++) begin
            cache_key[i]    = '0;
            cache_handle[i] = '0;
            cache_valid[i]  = 1'b0;
        end
        hit_total  = '0;
        miss_total = '0;
    endfunction

    function automatic t_out cache_step(t_in w);
        t_out r;
        logic [KEY_W-1:0] key;
        bit present;
        r = '0;
        key = {w.key_x, w.key_y, w.key_z};
        present = 1'b0;
        case (w.cmd)
            CMD_LOOKUP: begin
                // walk oldest to newest so the newest match wins
                for (int i = ENTRIES - 1; i >= 0; i--) begin
                    if (cache_valid[i] && cache_key[i] == key) begin
                        r.hit = 1'b1;
                        r.found_handle = cache_handle[i];
                    end
                end
                if (r.hit) begin
                    if (hit_total != '1) hit_total++;
                end else begin
                    if (miss_total != '1) miss_total++;
                end
            end
            CMD_PUSH: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (cache_valid[i] && cache_handle[i] == w.handle) present = 1'b1;
                end
                if (!present) begin
                    for (int i = ENTRIES - 1; i > 0; i--) begin
                        cache_key[i]    = cache_key[i-1];
                        cache_handle[i] = cache_handle[i-1];
                        cache_valid[i]  = cache_valid[i-1];
                    end
                    cache_key[0]    = key;
                    cache_handle[0] = w.handle;
                    cache_valid[0]  = 1'b1;
                end
            end
            CMD_CLEAR: begin
                for (int i = 0; i < ENTRIES; i++) cache_valid[i] = 1'b0;
            end
            default: begin
            end
        endcase
        r.hit_count  = hit_total;
        r.miss_count = miss_total;
        return r;
    endfunction

    task automatic add_row(t_cmd c, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                           logic [15:0] h, bit typed, t_out result);
        t_dir_row row;
        row.word   = {c, x, y, z, h};
        row.typed  = typed;
        row.result = result;
        dir_rows.push_back(row);
    endtask

    function automatic t_in random_word();
        t_in w;
        int unsigned pick;
        logic [KEY_W-1:0] key;
        pick = $urandom_range(0, 99);
        key = key_pool[$urandom_range(0, 11)];
        if ($urandom_range(0, 9) == 0) key = KEY_W'({$urandom, $urandom});
        w.handle = HDL_W'($urandom);
        if (pick < 40) begin
            w.cmd = CMD_LOOKUP;
        end else if (pick < 75) begin
            w.cmd = CMD_PUSH;
            if ($urandom_range(0, 9) < 7) w.handle = HDL_W'($urandom_range(0, 15));
            if ($urandom_range(0, 19) == 0)
                key_pool[$urandom_range(0, 11)] = KEY_W'({$urandom, $urandom});
        end else if (pick < 78) begin
            w.cmd = CMD_CLEAR;
        end else if (pick < 82) begin
            w.cmd = CMD_NOP;
        end else begin
            w.cmd = t_cmd'($urandom_range(0, 3));
            key = KEY_W'({$urandom, $urandom});
        end
        {w.key_x, w.key_y, w.key_z} = key;
        return w;
    endfunction

    // offer one word, record its expected result once accepted, then pace the sender
    task automatic offer_word(t_in w, bit typed, t_out typed_result);
        t_out want;
        int unsigned gap;
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        want = cache_step(w);
        if (typed) want = typed_result;
        expected_words.push_back(want);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    initial begin
        cache_clear_all();
        add_row(CMD_LOOKUP, 0, 0, 0, 0, 1, {1'b0, 16'h0000, 32'd0, 32'd1});
        add_row(CMD_NOP, 0, 0, 0, 0, 1, {1'b0, 16'h0000, 32'd0, 32'd1});
        // handle zero is an ordinary handle
        add_row(CMD_PUSH, 0, 0, 0, 0, 1, {1'b0, 16'h0000, 32'd0, 32'd1});
        add_row(CMD_LOOKUP, 0, 0, 0, 16'hffff, 1, {1'b1, 16'h0000, 32'd1, 32'd1});
        add_row(CMD_PUSH, 16'h8000, 16'h7fff, 16'hffff, 16'hffff, 1,
                {1'b0, 16'h0000, 32'd1, 32'd1});
        add_row(CMD_LOOKUP, 16'h8000, 16'h7fff, 16'hffff, 0, 1,
                {1'b1, 16'hffff, 32'd2, 32'd1});
        // present handle with another key is ignored
        add_row(CMD_PUSH, 7, 7, 7, 16'hffff, 1, {1'b0, 16'h0000, 32'd2, 32'd1});
        add_row(CMD_LOOKUP, 7, 7, 7, 0, 1, {1'b0, 16'h0000, 32'd2, 32'd2});
        // same key twice, newest slot wins
        add_row(CMD_PUSH, 16'h8000, 16'h7fff, 16'hffff, 16'h1234, 0, '0);
        add_row(CMD_LOOKUP, 16'h8000, 16'h7fff, 16'hffff, 0, 0, '0);
        for (int i = 1; i <= 6; i++) begin
            add_row(CMD_PUSH, 16'(i), 16'(-i), 16'(i * 1000), 16'(i), 0, '0);
        end
        // oldest entry has been dropped by now
        add_row(CMD_LOOKUP, 0, 0, 0, 0, 0, '0);
        add_row(CMD_LOOKUP, 16'h8000, 16'h7fff, 16'hffff, 0, 0, '0);
        add_row(CMD_PUSH, 0, 0, 0, 0, 0, '0);
        add_row(CMD_CLEAR, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 0, '0);
        add_row(CMD_LOOKUP, 0, 0, 0, 0, 0, '0);
        add_row(CMD_PUSH, 16'h7fff, 16'h8000, 0, 16'hffff, 0, '0);
        add_row(CMD_LOOKUP, 16'h7fff, 16'h8000, 0, 0, 0, '0);
        add_row(CMD_NOP, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 0, '0);

        foreach (key_pool[i]) key_pool[i] = KEY_W'({$urandom, $urandom});
        key_pool[0] = '0;
        key_pool[1] = '1;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) offer_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].result);
        for (int n = 0; n < 950; n++) begin
            if (n == 400) stall_request = 1'b1;
            offer_word(random_word(), 0, '0);
        end
        i_in_valid <= 1'b0;

        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("fifo_region_chunk_cache test passed");
        end else begin
            $display("fifo_region_chunk_cache test failed");
        end
        $finish;
    end

    // receiver: stretches of differing readiness, plus one long hold-off
    initial begin
        int unsigned ready_pct;
        int unsigned stretch_left;
        stretch_left = 0;
        ready_pct = 100;
        forever begin
            if (stretch_left == 0) begin
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 75;
                    2: ready_pct = 40;
                    default: ready_pct = 10;
                endcase
                stretch_left = $urandom_range(20, 120);
            end
            stretch_left--;
            if (stall_request) begin
                stall_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(1, 100) <= ready_pct);
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word: hit=%0d handle=%h hits=%0d misses=%0d",
                             o_out_data.hit, o_out_data.found_handle,
                             o_out_data.hit_count, o_out_data.miss_count);
            end else begin
                want = expected_words.pop_front();
                if (o_out_data.hit !== want.hit
                        || o_out_data.found_handle !== want.found_handle
                        || o_out_data.hit_count !== want.hit_count
                        || o_out_data.miss_count !== want.miss_count) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch at %0t: expected hit=%0d handle=%h hits=%0d ",
                                  "misses=%0d, got hit=%0d handle=%h hits=%0d misses=%0d"},
                                 $realtime, want.hit, want.found_handle, want.hit_count,
                                 want.miss_count, o_out_data.hit, o_out_data.found_handle,
                                 o_out_data.hit_count, o_out_data.miss_count);
                end
            end
        end
    end

endmodule

// ===== files.f =====
hw/rtl/fcc_pkg.sv
hw/rtl/fcc_cmp.sv
hw/rtl/fcc_seq.sv
hw/rtl/fifo_region_chunk_cache.sv
verif/testbench.sv
